// File: rtl/ufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned CNT_W  = 3;   // results per byte, 0 to 4

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

	// one byte's worth of results: (count - 1) replacements, then last_cp
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CP_W-1:0]  last_cp;
		logic             done;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/ufd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ufd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic [ufd_pkg::BYTE_W-1:0]   text_byte,
	input  wire logic                         end_of_text,
	output      logic                         cmd_push,
	output      ufd_pkg::cmd_t                cmd
);
	import ufd_pkg::*;

	logic [1:0]      needed_q;
	logic [1:0]      seen_q;
	logic [CP_W-1:0] partial_q;

	logic [1:0]      needed_d;
	logic [1:0]      seen_d;
	logic [CP_W-1:0] partial_d;

	logic            pending;
	logic            is_cont;
	logic            is_ascii;
	logic            lead2;
	logic            lead3;
	logic            lead4;
	logic [1:0]      seen_inc;
	logic [CP_W-1:0] shifted;
	logic [CNT_W-1:0] pre;

	always_comb begin
		pending  = (needed_q != 2'd0);
		is_cont  = (text_byte[7:6] == 2'b10);
		is_ascii = !text_byte[7];
		lead2    = (text_byte[7:5] == 3'b110);
		lead3    = (text_byte[7:4] == 4'b1110);
		lead4    = (text_byte[7:3] == 5'b11110);
		seen_inc = seen_q + 2'd1;
		shifted  = {partial_q[CP_W-7:0], text_byte[5:0]};
		// replacements owed by a broken sequence: the lead plus each continuation
		pre      = pending ? ({1'b0, seen_q} + 3'd1) : 3'd0;

		needed_d     = needed_q;
		seen_d       = seen_q;
		partial_d    = partial_q;
		cmd.count    = 3'd0;
		cmd.last_cp  = REPLACEMENT;
		cmd.done     = end_of_text;

		if (pending && is_cont) begin
			if (seen_inc == needed_q) begin
				cmd.count   = 3'd1;
				cmd.last_cp = shifted;
				needed_d    = 2'd0;
				seen_d      = 2'd0;
				partial_d   = '0;
			end else if (end_of_text) begin
				cmd.count   = {1'b0, seen_inc} + 3'd1;
				needed_d    = 2'd0;
				seen_d      = 2'd0;
				partial_d   = '0;
			end else begin
				seen_d      = seen_inc;
				partial_d   = shifted;
			end
		end else begin
			needed_d  = 2'd0;
			seen_d    = 2'd0;
			partial_d = '0;
			priority if (is_ascii) begin
				cmd.count   = pre + 3'd1;
				cmd.last_cp = {{(CP_W-BYTE_W){1'b0}}, text_byte};
			end else if (lead2 || lead3 || lead4) begin
				if (end_of_text) begin
					cmd.count = pre + 3'd1;
				end else begin
					cmd.count = pre;
					seen_d    = 2'd0;
					priority if (lead2) begin
						needed_d  = 2'd1;
						partial_d = {{(CP_W-5){1'b0}}, text_byte[4:0]};
					end else if (lead3) begin
						needed_d  = 2'd2;
						partial_d = {{(CP_W-4){1'b0}}, text_byte[3:0]};
					end else begin
						needed_d  = 2'd3;
						partial_d = {{(CP_W-3){1'b0}}, text_byte[2:0]};
					end
				end
			end else begin
				cmd.count = pre + 3'd1;
			end
		end

		cmd_push = take && (cmd.count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q  <= 2'd0;
			seen_q    <= 2'd0;
			partial_q <= '0;
		end else if (take) begin
			needed_q  <= needed_d;
			seen_q    <= seen_d;
			partial_q <= partial_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ufd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ufd_cmd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire ufd_pkg::cmd_t wr_data,
	input  wire logic          rd_en,
	output      ufd_pkg::cmd_t rd_data,
	output      logic          full,
	output      logic          empty
);
	import ufd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ufd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ufd_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_empty,
	input  wire ufd_pkg::cmd_t              cmd,
	output      logic                       cmd_pop,
	input  wire logic                       pop,
	output      logic                       empty,
	output      logic [ufd_pkg::CP_W-1:0]   code_point,
	output      logic                       last_of_run,
	output      logic                       text_done
);
	import ufd_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] rem_q;
	logic [CP_W-1:0]  last_cp_q;
	logic             done_q;
	logic             on_last;
	logic             load;

	assign on_last     = (rem_q == 3'd1);
	assign empty       = !busy_q;
	assign code_point  = on_last ? last_cp_q : REPLACEMENT;
	assign last_of_run = on_last;
	assign text_done   = on_last && done_q;

	// take the next command once the current one has handed out its last request
	assign load    = !busy_q || (pop && on_last);
	assign cmd_pop = load && !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (load) begin
			busy_q <= !cmd_empty;
			if (!cmd_empty) begin
				rem_q <= cmd.count;
			end
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			last_cp_q <= cmd.last_cp;
			done_q    <= cmd.done;
		end
	end

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Lax UTF-8 decoder: one byte per push, zero to four code points per byte on the
// result side (U+FFFD for each malformed byte, including the lead and continuations
// of a sequence that breaks off or is cut by end_of_text). The front decodes a byte
// in the cycle it is taken and can take a new byte every clock while the command
// queue (CMD_DEPTH entries) has room; a result goes through the queue into the back.
// The back hands out one result per clock while pop is held; a byte with several
// results keeps it busy; well-formed text sustains one byte per clock.
module utf8_stream_decoder #(
	parameter int unsigned CMD_DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output      logic                       full,
	input  wire logic [ufd_pkg::BYTE_W-1:0] text_byte,
	input  wire logic                       end_of_text,
	output      logic                       empty,
	input  wire logic                       pop,
	output      logic [ufd_pkg::CP_W-1:0]   code_point,
	output      logic                       last_of_run,
	output      logic                       text_done
);
	import ufd_pkg::*;

	logic take;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_pop;
	logic cmd_empty;

	assign take = push && !full;

	ufd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	ufd_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (full),
		.empty   (cmd_empty)
	);

	ufd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

endmodule

`default_nettype wire
